// ===== rtl/eckf_pkg.sv =====
// Shared types, constants and codes for the elevation cell fusion unit.
package eckf_pkg;

    localparam int GRID_COLS_DEF = 64;
    localparam int GRID_ROWS_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        ST_OUTSIDE = 2'd0,
        ST_INSERT  = 2'd1,
        ST_FUSE    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_ORIGIN_X   = 2'd0,
        REG_ORIGIN_Y   = 2'd1,
        REG_CELL_SHIFT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] meas_height;
        logic        [31:0] meas_variance;
    } item_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         cell_col;
        logic [5:0]         cell_row;
        logic signed [31:0] new_height;
        logic        [31:0] new_variance;
    } item_out_t;

    // Classified landmark handed from front to back end
    typedef struct packed {
        logic               in_grid;
        logic [11:0]        col;
        logic [11:0]        row;
        logic signed [31:0] meas_height;
        logic        [31:0] meas_variance;
    } task_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_PREP,
        BK_MUL,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage

// ===== rtl/eckf_front.sv =====
// Front end: subtracts the grid origin, maps to a cell and classifies.
module eckf_front
    import eckf_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  item_in_t           in_item,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic [4:0]         cell_shift,
    output logic               task_valid,
    output task_t              task_data,
    input  logic               task_pop
);

    logic signed [32:0] dx, dy;
    logic [32:0]        colw, roww;
    task_t              cls;
    logic               full_reg, full_next;
    task_t              data_reg;

    // Cell mapping
    always_comb
    begin
        dx   = 33'(signed'(in_item.pos_x)) - 33'(signed'(origin_x));
        dy   = 33'(signed'(in_item.pos_y)) - 33'(signed'(origin_y));
        colw = 33'(dx) >> cell_shift;
        roww = 33'(dy) >> cell_shift;
        cls.in_grid = !dx[32] && !dy[32] &&
                      (colw < 33'(GRID_COLS)) && (roww < 33'(GRID_ROWS));
        cls.col = colw[11:0];
        cls.row = roww[11:0];
        cls.meas_height   = in_item.meas_height;
        cls.meas_variance = in_item.meas_variance;
    end

    // One-entry hold stage toward the queue
    always_comb
    begin
        full_next = full_reg;
        if (task_pop)
            full_next = 1'b0;
        if (in_valid)
            full_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            data_reg <= cls;
    end

    assign task_valid = full_reg;
    assign task_data  = data_reg;

endmodule

// ===== rtl/eckf_queue.sv =====
// Short queue between the front and back ends.
module eckf_queue
    import eckf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  task_t push_data,
    output logic  push_ok,
    output logic  pop_valid,
    output task_t pop_data,
    input  logic  pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    task_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wp_reg, rp_reg;
    logic [PW:0]    cnt_reg;
    logic           do_push, do_pop;

    assign do_push   = push && (cnt_reg != (PW+1)'(QUEUE_DEPTH));
    assign do_pop    = pop && (cnt_reg != '0);
    assign push_ok   = do_push;
    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = slot_reg[rp_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wp_reg <= wp_reg + 1'b1;
            if (do_pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wp_reg] <= push_data;
    end

endmodule

// ===== rtl/eckf_back.sv =====
// Back end: cell stores, Kalman update and bit-serial rounding divider.
module eckf_back
    import eckf_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      task_valid,
    input  task_t     task_data,
    output logic      task_pop,
    output logic      result_valid,
    output item_out_t result_item,
    output logic      sweeping
);

    localparam int CELLS = GRID_COLS * GRID_ROWS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    // Stores; valid bits cleared by a sweep after reset
    logic [31:0]  hmem [CELLS];
    logic [31:0]  vmem [CELLS];
    logic         vbit [CELLS];
    logic [31:0]  hp_reg, vp_reg;
    logic         vb_reg;

    back_state_t  st_reg, st_next;
    task_t        t_reg;
    logic [AW-1:0] idx_reg;
    logic [AW:0]  clr_reg;
    logic         clr_busy;

    logic         neg_reg;
    logic [32:0]  s_reg;
    logic [32:0]  mag_reg;
    logic [63:0]  nh_reg, nv_reg;    // numerators, shifted out MSB first
    logic [32:0]  rh_reg, rv_reg;    // partial remainders
    logic [63:0]  qh_reg, qv_reg;
    logic [6:0]   bit_reg;
    logic [33:0]  trh, trv;
    logic         wr_en;
    logic [31:0]  wr_h, wr_v;
    logic signed [33:0] hsum;
    logic [31:0]  hsat;

    assign clr_busy = !clr_reg[AW] ? 1'b1 : 1'b0;
    assign sweeping = clr_busy;

    // Control
    always_comb
    begin
        st_next  = st_reg;
        task_pop = 1'b0;
        unique case (st_reg)
            BK_IDLE: if (task_valid && !clr_busy)
            begin
                task_pop = 1'b1;
                st_next  = BK_READ;
            end
            BK_READ: st_next = t_reg.in_grid ? BK_PREP : BK_DONE;
            BK_PREP: st_next = vb_reg ? BK_MUL : BK_IDLE;
            BK_MUL:  st_next = BK_DIV;
            BK_DIV:  if (bit_reg == 7'd0) st_next = BK_IDLE;
            BK_DONE: st_next = BK_IDLE;
            default: st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= BK_IDLE;
            clr_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (clr_busy)
                clr_reg <= clr_reg + 1'b1;
        end
    end

    // Restoring division steps, one quotient bit each for height and variance
    assign trh = {rh_reg, nh_reg[63]} - {1'b0, s_reg};
    assign trv = {rv_reg, nv_reg[63]} - {1'b0, s_reg};

    // Rounded height and saturation
    always_comb
    begin
        // quotient plus rounding: q = (num + s/2) / s folded into numerator
        hsum = neg_reg ? (34'(signed'(hp_reg)) - signed'(34'(qh_reg[32:0])))
                       : (34'(signed'(hp_reg)) + signed'(34'(qh_reg[32:0])));
        if (qh_reg[63:33] != '0)
            hsat = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else if (hsum > 34'sh0_7FFF_FFFF)
            hsat = 32'h7FFF_FFFF;
        else if (hsum < -34'sh0_8000_0000)
            hsat = 32'h8000_0000;
        else
            hsat = hsum[31:0];
    end

    always_comb
    begin
        wr_en = 1'b0;
        wr_h  = t_reg.meas_height;
        wr_v  = t_reg.meas_variance;
        if (st_reg == BK_PREP && !vb_reg)
            wr_en = 1'b1;
        if (st_reg == BK_DIV && bit_reg == 7'd0 && vb_reg && s_reg != '0)
        begin
            wr_en = 1'b1;
            wr_h  = hsat;
            wr_v  = qv_reg[31:0];
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (task_pop)
        begin
            t_reg   <= task_data;
            idx_reg <= AW'(task_data.row * GRID_COLS + task_data.col);
        end
        if (st_reg == BK_READ)
        begin
            hp_reg <= hmem[idx_reg];
            vp_reg <= vmem[idx_reg];
            vb_reg <= vbit[idx_reg];
        end
        if (clr_busy)
            vbit[clr_reg[AW-1:0]] <= 1'b0;
        else if (wr_en)
            vbit[idx_reg] <= 1'b1;
        if (wr_en)
        begin
            hmem[idx_reg] <= wr_h;
            vmem[idx_reg] <= wr_v;
        end
        if (st_reg == BK_PREP)
        begin
            s_reg   <= {1'b0, vp_reg} + {1'b0, t_reg.meas_variance};
            neg_reg <= (34'(signed'(t_reg.meas_height)) < 34'(signed'(hp_reg)));
            mag_reg <= (34'(signed'(t_reg.meas_height)) < 34'(signed'(hp_reg)))
                     ? 33'(34'(signed'(hp_reg)) - 34'(signed'(t_reg.meas_height)))
                     : 33'(34'(signed'(t_reg.meas_height)) - 34'(signed'(hp_reg)));
        end
        if (st_reg == BK_MUL)
        begin
            nh_reg  <= mag_reg[31:0] * vp_reg + 64'(s_reg[32:1]);
            nv_reg  <= t_reg.meas_variance * vp_reg + 64'(s_reg[32:1]);
            rh_reg  <= '0;
            rv_reg  <= '0;
            qh_reg  <= '0;
            qv_reg  <= '0;
            bit_reg <= 7'd64;
        end
        // 64 steps; quotients are complete once bit_reg reaches zero
        if (st_reg == BK_DIV && bit_reg != 7'd0)
        begin
            nh_reg <= {nh_reg[62:0], 1'b0};
            nv_reg <= {nv_reg[62:0], 1'b0};
            if (!trh[33])
            begin
                rh_reg <= trh[32:0];
                qh_reg <= {qh_reg[62:0], 1'b1};
            end
            else
            begin
                rh_reg <= {rh_reg[31:0], nh_reg[63]};
                qh_reg <= {qh_reg[62:0], 1'b0};
            end
            if (!trv[33])
            begin
                rv_reg <= trv[32:0];
                qv_reg <= {qv_reg[62:0], 1'b1};
            end
            else
            begin
                rv_reg <= {rv_reg[31:0], nv_reg[63]};
                qv_reg <= {qv_reg[62:0], 1'b0};
            end
            bit_reg <= bit_reg - 7'd1;
        end
    end

    // Result strobe
    logic      rv_out_reg;
    item_out_t ro_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_out_reg <= 1'b0;
        else
            rv_out_reg <= (st_reg == BK_DONE) ||
                          (st_reg == BK_PREP && !vb_reg) ||
                          (st_reg == BK_DIV && bit_reg == 7'd0);
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == BK_DONE)
            ro_reg <= '0;
        else if (st_reg == BK_PREP && !vb_reg)
            ro_reg <= '{ST_INSERT, t_reg.col[5:0], t_reg.row[5:0],
                        t_reg.meas_height, t_reg.meas_variance};
        else if (st_reg == BK_DIV && bit_reg == 7'd0)
            ro_reg <= '{ST_FUSE, t_reg.col[5:0], t_reg.row[5:0],
                        (s_reg != '0) ? hsat : hp_reg,
                        (s_reg != '0) ? qv_reg[31:0] : vp_reg};
    end

    assign result_valid = rv_out_reg;
    assign result_item  = ro_reg;

endmodule

// ===== rtl/elevation_cell_kalman_fusion_unit.sv =====
// Top level of the elevation cell Kalman fusion unit.
// A landmark transfers at a clock edge with start high and busy low; busy then stays high
// until the edge that ends the done cycle, so one landmark is in flight at a time. done
// is registered behind the front hold stage, the queue and the back-end states READ and
// DONE for points outside the grid, READ and PREP for the first hit on a cell, and READ,
// PREP, MUL and DIV when fusing into a valid cell; DIV runs the 64-step restoring divider
// that forms both rounded Kalman quotients. The next landmark can transfer once busy falls
// after done. done lasts one cycle and cannot be held off. After reset the cell valid
// bits are swept clear (all GRID_COLS*GRID_ROWS of them, 4096 by default) while busy
// stays high; configuration writes are taken at any time but belong where no landmark
// is in flight.
module elevation_cell_kalman_fusion_unit
    import eckf_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  item_in_t   in_item,
    output logic       done,
    output item_out_t  out_item,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_data
);

    logic signed [31:0] origin_x_reg, origin_y_reg;
    logic [4:0]         cell_shift_reg;
    logic               f_valid, q_ok, q_valid, q_pop, acc;
    task_t              f_data, q_data;
    logic               pend_reg;
    logic               sweeping;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            cell_shift_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:   origin_x_reg   <= cfg_data;
                REG_ORIGIN_Y:   origin_y_reg   <= cfg_data;
                REG_CELL_SHIFT: cell_shift_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // One item in flight at a time
    assign acc = start && !busy;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else if (acc)
            pend_reg <= 1'b1;
        else if (done)
            pend_reg <= 1'b0;
    end
    assign busy = pend_reg || sweeping;

    eckf_front #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(acc), .in_item(in_item),
        .origin_x(origin_x_reg), .origin_y(origin_y_reg),
        .cell_shift(cell_shift_reg),
        .task_valid(f_valid), .task_data(f_data), .task_pop(q_ok)
    );

    eckf_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(f_valid), .push_data(f_data),
        .push_ok(q_ok), .pop_valid(q_valid), .pop_data(q_data), .pop(q_pop)
    );

    eckf_back #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_back (
        .clk(clk), .rst_n(rst_n), .task_valid(q_valid), .task_data(q_data),
        .task_pop(q_pop), .result_valid(done), .result_item(out_item),
        .sweeping(sweeping)
    );

endmodule

// ===== rtl/eckf_checker.sv =====
// Port-level checker for the fusion unit, bound to the top level.
module eckf_checker
    import eckf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input item_out_t out_item
);

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("busy not raised");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than a cycle");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (out_item.status == ST_OUTSIDE || out_item.status == ST_INSERT ||
                  out_item.status == ST_FUSE)) else $error("bad status");
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_item.status == ST_OUTSIDE) |-> (out_item.new_height == '0 &&
        out_item.new_variance == '0)) else $error("outside result not zero");
    a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done while idle");

endmodule

bind elevation_cell_kalman_fusion_unit eckf_checker u_eckf_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .out_item(out_item)
);
